// ----- src/scu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stick calibration scaler package
// Shared constants, widths and the divider cell record.
// ----------------------------------------------------------------------------
package scu_pkg;

    localparam int MID_LOG2     = 11;
    localparam int MID_VALUE    = 1 << MID_LOG2;
    localparam int MAX_VALUE    = 4095;
    localparam int EDGE_MARGIN  = 10;
    localparam int CHANNELS     = 4;
    localparam int INV_CHANNELS = 2;

    localparam int CH_W     = 3;
    localparam int SAMPLE_W = 16;
    localparam int ADC_W    = 12;
    localparam int WIDE_W   = SAMPLE_W + 2;
    localparam int REM_W    = SAMPLE_W + 1;
    localparam int QUO_W    = MID_LOG2 + 1;
    localparam int VAL_W    = $clog2(2 * MID_VALUE + 2);
    localparam int NCELLS   = QUO_W;

    typedef struct packed {
        logic [REM_W-1:0]    rem;
        logic [SAMPLE_W-1:0] div;
        logic [QUO_W-1:0]    quo;
        logic                below;
        logic                bad;
        logic                in_range;
        logic                invert;
    } scu_cell_t;

endpackage

// ----- src/scu_prep.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stick calibration scaler front stage
// Selects the half range, forms numerator and divisor, flags bad calibration.
// ----------------------------------------------------------------------------
module scu_prep
    import scu_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic                       in_valid,
    input  logic                       reverse_all,
    input  logic [CH_W-1:0]            channel,
    input  logic signed [SAMPLE_W-1:0] raw_sample,
    input  logic signed [SAMPLE_W-1:0] cal_min,
    input  logic signed [SAMPLE_W-1:0] cal_mid,
    input  logic signed [SAMPLE_W-1:0] cal_max,
    output logic                       prep_valid,
    output scu_cell_t                  prep_data
);

    logic                     valid_reg;
    logic                     valid_next;
    scu_cell_t                data_reg;
    scu_cell_t                data_next;
    logic signed [WIDE_W-1:0] raw_w;
    logic signed [WIDE_W-1:0] min_w;
    logic signed [WIDE_W-1:0] mid_w;
    logic signed [WIDE_W-1:0] max_w;
    logic signed [WIDE_W-1:0] div_w;
    logic signed [WIDE_W-1:0] num_w;
    logic                     below;

    always_comb
    begin
        raw_w = WIDE_W'(raw_sample);
        min_w = WIDE_W'(cal_min);
        mid_w = WIDE_W'(cal_mid);
        max_w = WIDE_W'(cal_max);
        below = raw_w < mid_w;
        if (below)
        begin
            div_w = mid_w - min_w - WIDE_W'(EDGE_MARGIN);
            num_w = mid_w - raw_w;
        end
        else
        begin
            div_w = max_w - WIDE_W'(EDGE_MARGIN) - mid_w;
            num_w = raw_w - mid_w;
        end
        data_next.rem      = {1'b0, num_w[SAMPLE_W-1:0]};
        data_next.div      = div_w[SAMPLE_W-1:0];
        data_next.quo      = '0;
        data_next.below    = below;
        data_next.bad      = div_w <= 0;
        data_next.in_range = {1'b0, channel} < (CH_W + 1)'(CHANNELS);
        data_next.invert   = reverse_all || ({1'b0, channel} < (CH_W + 1)'(INV_CHANNELS));
        valid_next         = advance ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign prep_valid = valid_reg;
    assign prep_data  = data_reg;

endmodule

// ----- src/scu_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stick calibration scaler divider cell
// One restoring step: compare, subtract, shift in one quotient bit.
// ----------------------------------------------------------------------------
module scu_div_cell
    import scu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  logic      cell_in_valid,
    input  scu_cell_t cell_in,
    output logic      cell_out_valid,
    output scu_cell_t cell_out
);

    logic             valid_reg;
    logic             valid_next;
    scu_cell_t        data_reg;
    scu_cell_t        data_next;
    logic [REM_W-1:0] diff;
    logic [REM_W-1:0] rem_kept;
    logic             ge;

    always_comb
    begin
        ge        = cell_in.rem >= {1'b0, cell_in.div};
        diff      = cell_in.rem - {1'b0, cell_in.div};
        rem_kept  = ge ? diff : cell_in.rem;
        data_next = cell_in;
        data_next.rem = {rem_kept[REM_W-2:0], 1'b0};
        data_next.quo = {cell_in.quo[QUO_W-2:0], ge};
        valid_next    = advance ? cell_in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign cell_out_valid = valid_reg;
    assign cell_out       = data_reg;

endmodule

// ----- src/scu_post.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stick calibration scaler output stage
// Saturates deflection, forms, clamps and inverts the position; holds it.
// ----------------------------------------------------------------------------
module scu_post
    import scu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             post_in_valid,
    input  scu_cell_t        post_in,
    output logic             out_valid,
    output logic [ADC_W-1:0] adc_value,
    output logic             bad_calibration
);

    logic             valid_reg;
    logic             valid_next;
    logic [ADC_W-1:0] adc_reg;
    logic [ADC_W-1:0] adc_next;
    logic             bad_reg;
    logic             bad_next;
    logic [QUO_W-1:0] defl;
    logic [VAL_W-1:0] val;
    logic [VAL_W-1:0] val_sat;

    always_comb
    begin
        if (post_in.bad || post_in.quo[QUO_W-1])
        begin
            defl = QUO_W'(MID_VALUE);
        end
        else
        begin
            defl = {1'b0, post_in.quo[QUO_W-2:0]};
        end
        if (post_in.below)
        begin
            val = VAL_W'(MID_VALUE) - VAL_W'(defl);
        end
        else
        begin
            val = VAL_W'(MID_VALUE) + VAL_W'(defl) + VAL_W'(1);
        end
        val_sat = (val > VAL_W'(MAX_VALUE)) ? VAL_W'(MAX_VALUE) : val;
        if (!post_in.in_range)
        begin
            adc_next = '0;
        end
        else if (post_in.invert)
        begin
            adc_next = ADC_W'(MAX_VALUE) - val_sat[ADC_W-1:0];
        end
        else
        begin
            adc_next = val_sat[ADC_W-1:0];
        end
        bad_next   = post_in.in_range && post_in.bad;
        valid_next = advance ? post_in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            adc_reg <= adc_next;
            bad_reg <= bad_next;
        end
    end

    assign out_valid       = valid_reg;
    assign adc_value       = adc_reg;
    assign bad_calibration = bad_reg;

endmodule

// ----- src/stick_calibration_scaler_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stick calibration scaler
// Three-point calibration of one stick sample into a centered ADC position.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall carry channel, raw_sample, cal_min,
//   cal_mid and cal_max. An item is taken when in_valid is high and in_stall
//   is low. Output channel: out_valid / out_stall carry adc_value and
//   bad_calibration under the same rule.
//   Configuration: cfg_valid / cfg_ready write cfg_data into reverse_all;
//   cfg_ready is always high. Write it only while the block is idle.
//   Pipeline: an accepted item passes the front stage, twelve divider
//   cells for the saturation bit and eleven quotient bits, and the output
//   register. Throughput: one item per cycle while the chain is not held;
//   the divider is a chain of restoring cells, each resolving one bit and
//   passing its remainder on whenever the chain advances.
//   Reset: all stage valid bits and reverse_all clear; the pipeline is empty.
//   Stall: while an item waits in the output register with out_stall high,
//   the whole chain holds and in_stall is raised.
// ----------------------------------------------------------------------------
module stick_calibration_scaler_unit
    import scu_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [CH_W-1:0]            channel,
    input  logic signed [SAMPLE_W-1:0] raw_sample,
    input  logic signed [SAMPLE_W-1:0] cal_min,
    input  logic signed [SAMPLE_W-1:0] cal_mid,
    input  logic signed [SAMPLE_W-1:0] cal_max,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [ADC_W-1:0]           adc_value,
    output logic                       bad_calibration,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_data
);

    logic      reverse_all_reg;
    logic      reverse_all_next;
    logic      advance;
    logic      chain_valid [NCELLS+1];
    scu_cell_t chain_data  [NCELLS+1];

    assign advance   = !(out_valid && out_stall);
    assign in_stall  = !advance;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        reverse_all_next = (cfg_valid && cfg_ready) ? cfg_data : reverse_all_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reverse_all_reg <= 1'b0;
        end
        else
        begin
            reverse_all_reg <= reverse_all_next;
        end
    end

    scu_prep u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_valid    (in_valid),
        .reverse_all (reverse_all_reg),
        .channel     (channel),
        .raw_sample  (raw_sample),
        .cal_min     (cal_min),
        .cal_mid     (cal_mid),
        .cal_max     (cal_max),
        .prep_valid  (chain_valid[0]),
        .prep_data   (chain_data[0])
    );

    for (genvar i = 0; i < NCELLS; i++)
    begin : g_cell
        scu_div_cell u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .advance        (advance),
            .cell_in_valid  (chain_valid[i]),
            .cell_in        (chain_data[i]),
            .cell_out_valid (chain_valid[i+1]),
            .cell_out       (chain_data[i+1])
        );
    end

    scu_post u_post (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .post_in_valid   (chain_valid[NCELLS]),
        .post_in         (chain_data[NCELLS]),
        .out_valid       (out_valid),
        .adc_value       (adc_value),
        .bad_calibration (bad_calibration)
    );

`ifndef NO_ASSERTIONS
    a_bad_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_calibration |->
            (adc_value == '0 || adc_value == ADC_W'(MAX_VALUE)))
        else $error("bad calibration item not saturated");

    a_chain_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[NCELLS] && advance |=> out_valid)
        else $error("item lost between last cell and output register");

    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output register");
`endif

endmodule

// ----- tb/tb_stick_calibration_scaler_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stick calibration scaler testbench
// Drives calibrated stick samples through the scaler and compares every
// position and flag to the table for typed rows with reverse off, else to
// a local three-point calibration predictor. Phases vary sender gaps,
// receiver stalls and the reverse setting; each runs random samples
// (mostly well-formed, some noise), the first two after the edge cases.
// ----------------------------------------------------------------------------
module tb_stick_calibration_scaler_unit;
    import scu_pkg::*;

    localparam int LATENCY          = 14;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int RANDOM_PER_PHASE = 150;
    localparam int PHASES           = 4;
    localparam int DIRECTED_ROWS    = 23;

    typedef struct packed {
        logic [CH_W-1:0]            channel;
        logic signed [SAMPLE_W-1:0] raw;
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] mid;
        logic signed [SAMPLE_W-1:0] hi;
    } stick_sample_t;

    typedef struct packed {
        logic [ADC_W-1:0] adc;
        logic             bad;
    } stick_position_t;

    typedef struct packed {
        logic                       typed;
        logic [CH_W-1:0]            channel;
        logic signed [SAMPLE_W-1:0] raw;
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] mid;
        logic signed [SAMPLE_W-1:0] hi;
        logic [ADC_W-1:0]           adc;
        logic                       bad;
    } sample_row_t;

    // typed, channel, raw, min, mid, max, adc_value, bad_calibration
    sample_row_t directed_rows [DIRECTED_ROWS] = '{
        '{1'b1, 3'd4, 16'sd0,     -16'sd100,  16'sd0,     16'sd100,   12'd0,    1'b0},
        '{1'b1, 3'd7, 16'sh7FFF,  16'sh8000,  16'sd0,     16'sh7FFF,  12'd0,    1'b0},
        '{1'b1, 3'd5, 16'sh8000,  16'sh7FFF,  16'sh8000,  16'sh8000,  12'd0,    1'b0},
        '{1'b1, 3'd2, 16'sd0,     -16'sd100,  16'sd0,     16'sd100,   12'd2049, 1'b0},
        '{1'b1, 3'd0, 16'sd0,     -16'sd100,  16'sd0,     16'sd100,   12'd2046, 1'b0},
        '{1'b1, 3'd2, -16'sd5,    16'sd0,     16'sd0,     16'sd100,   12'd0,    1'b1},
        '{1'b1, 3'd3, 16'sd5,     -16'sd100,  16'sd0,     16'sd10,    12'd4095, 1'b1},
        '{1'b1, 3'd1, 16'sd5,     -16'sd100,  16'sd0,     16'sd10,    12'd0,    1'b1},
        '{1'b1, 3'd0, -16'sd5,    16'sd0,     16'sd0,     16'sd100,   12'd4095, 1'b1},
        '{1'b1, 3'd2, 16'sh7FFF,  16'sh8000,  16'sh8000,  16'sh7FFF,  12'd4095, 1'b0},
        '{1'b1, 3'd2, 16'sh8000,  16'sh8000,  16'sh7FFF,  16'sh7FFF,  12'd0,    1'b0},
        '{1'b1, 3'd0, 16'sh8000,  16'sh8000,  16'sh7FFF,  16'sh7FFF,  12'd4095, 1'b0},
        '{1'b1, 3'd3, 16'sh8000,  16'sh8000,  16'sh8000,  16'sh8000,  12'd4095, 1'b1},
        '{1'b1, 3'd2, 16'sh7FFF,  16'sh7FFF,  16'sh7FFF,  16'sh7FFF,  12'd4095, 1'b1},
        '{1'b0, 3'd2, 16'sd50,    -16'sd100,  16'sd0,     16'sd100,   12'd0,    1'b0},
        '{1'b0, 3'd3, -16'sd45,   -16'sd100,  16'sd0,     16'sd100,   12'd0,    1'b0},
        '{1'b0, 3'd1, 16'sd300,   -16'sd1000, 16'sd100,   16'sd1000,  12'd0,    1'b0},
        '{1'b0, 3'd0, -16'sd1000, -16'sd1000, 16'sd100,   16'sd1000,  12'd0,    1'b0},
        '{1'b0, 3'd2, 16'sd95,    -16'sd100,  16'sd0,     16'sd100,   12'd0,    1'b0},
        '{1'b0, 3'd2, -16'sd1,    -16'sd11,   16'sd0,     16'sd100,   12'd0,    1'b0},
        '{1'b0, 3'd3, 16'sd1,     -16'sd100,  16'sd0,     16'sd11,    12'd0,    1'b0},
        '{1'b0, 3'd2, 16'sh5555,  16'shAAAA,  16'sh1234,  16'sh7FF0,  12'd0,    1'b0},
        '{1'b0, 3'd1, 16'shAAAA,  16'sh8000,  16'sh0F0F,  16'sh5555,  12'd0,    1'b0}
    };

    int idle_tab  [PHASES] = '{0, 67, 0, 28};
    int stall_tab [PHASES] = '{0, 0, 67, 28};
    bit rev_tab   [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1};

    logic                       clk             = 1'b0;
    logic                       rst_n           = 1'b0;
    logic                       in_valid        = 1'b0;
    logic                       in_stall;
    logic [CH_W-1:0]            channel         = '0;
    logic signed [SAMPLE_W-1:0] raw_sample      = '0;
    logic signed [SAMPLE_W-1:0] cal_min         = '0;
    logic signed [SAMPLE_W-1:0] cal_mid         = '0;
    logic signed [SAMPLE_W-1:0] cal_max         = '0;
    logic                       out_valid;
    logic                       out_stall       = 1'b0;
    logic [ADC_W-1:0]           adc_value;
    logic                       bad_calibration;
    logic                       cfg_valid       = 1'b0;
    logic                       cfg_ready;
    logic                       cfg_data        = 1'b0;

    stick_position_t pending_positions [$];
    bit              reverse_all_q   = 1'b0;
    int              idle_pct        = 0;
    int              stall_pct       = 0;
    int              mismatch_count  = 0;
    int              quiet_cycles    = 0;

    stick_calibration_scaler_unit u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .channel         (channel),
        .raw_sample      (raw_sample),
        .cal_min         (cal_min),
        .cal_mid         (cal_mid),
        .cal_max         (cal_max),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .adc_value       (adc_value),
        .bad_calibration (bad_calibration),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic stick_position_t scale_stick(input stick_sample_t s, input bit reverse);
        stick_position_t pos;
        int  raw;
        int  lo;
        int  mid;
        int  hi;
        int  divisor;
        int  span;
        int  defl;
        int  val;
        bit  below;
        raw = int'(s.raw);
        lo  = int'(s.lo);
        mid = int'(s.mid);
        hi  = int'(s.hi);
        pos = '0;
        if (s.channel >= CHANNELS)
            return pos;
        below   = raw < mid;
        divisor = below ? mid - (lo + EDGE_MARGIN) : (hi - EDGE_MARGIN) - mid;
        span    = below ? mid - raw : raw - mid;
        if (divisor <= 0)
        begin
            pos.bad = 1'b1;
            defl    = MID_VALUE;
        end
        else
        begin
            defl = (MID_VALUE * span) / divisor;
            if (defl > MID_VALUE)
                defl = MID_VALUE;
        end
        val = below ? MID_VALUE - defl : MID_VALUE + defl + 1;
        if (val > MAX_VALUE)
            val = MAX_VALUE;
        if (val < 0)
            val = 0;
        if (reverse || s.channel < INV_CHANNELS)
            val = MAX_VALUE - val;
        pos.adc = val[ADC_W-1:0];
        return pos;
    endfunction

    function automatic int clip16(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic int near_edge(input int mid, input bit upper);
        int gap;
        gap = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(12000, 11);
        return clip16(upper ? mid + gap : mid - gap);
    endfunction

    function automatic stick_sample_t make_sample();
        stick_sample_t s;
        int            lo;
        int            mid;
        int            hi;
        int            raw;
        s.channel = ($urandom_range(9) < 8) ? CH_W'($urandom_range(CHANNELS - 1))
                                            : CH_W'($urandom_range(7));
        if ($urandom_range(99) < 15)
        begin
            s.raw = SAMPLE_W'($urandom);
            s.lo  = SAMPLE_W'($urandom);
            s.mid = SAMPLE_W'($urandom);
            s.hi  = SAMPLE_W'($urandom);
        end
        else
        begin
            mid = $urandom_range(40000);
            mid = mid - 20000;
            lo  = near_edge(mid, 1'b0);
            hi  = near_edge(mid, 1'b1);
            if ($urandom_range(9) == 0)
                raw = mid;
            else
            begin
                raw = $urandom_range(hi - lo + 400);
                raw = clip16(lo - 200 + raw);
            end
            s.raw = raw[SAMPLE_W-1:0];
            s.lo  = lo[SAMPLE_W-1:0];
            s.mid = mid[SAMPLE_W-1:0];
            s.hi  = hi[SAMPLE_W-1:0];
        end
        return s;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic send_sample(input stick_sample_t s, input stick_position_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        channel    <= s.channel;
        raw_sample <= s.raw;
        cal_min    <= s.lo;
        cal_mid    <= s.mid;
        cal_max    <= s.hi;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_positions.push_back(want);
    endtask

    task automatic write_reverse(input bit value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid     <= 1'b0;
        reverse_all_q = value;
    endtask

    task automatic wait_drained();
        while (pending_positions.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : position_check
        stick_position_t want;
        if (out_valid && !out_stall)
        begin
            if (pending_positions.size() == 0)
                report_mismatch($sformatf("unexpected item adc_value=%0d bad_calibration=%0b",
                                          adc_value, bad_calibration));
            else
            begin
                want = pending_positions.pop_front();
                if (adc_value !== want.adc)
                    report_mismatch($sformatf("adc_value got %0d expected %0d",
                                              adc_value, want.adc));
                if (bad_calibration !== want.bad)
                    report_mismatch($sformatf("bad_calibration got %0b expected %0b",
                                              bad_calibration, want.bad));
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_stick_calibration_scaler_unit: FAIL");
            $finish;
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial
    begin
        sample_row_t     row;
        stick_sample_t   s;
        stick_position_t want;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            write_reverse(rev_tab[p]);
            idle_pct  = idle_tab[p];
            stall_pct = stall_tab[p];
            if (p < 2)
            begin
                for (int i = 0; i < DIRECTED_ROWS; i++)
                begin
                    row       = directed_rows[i];
                    s.channel = row.channel;
                    s.raw     = row.raw;
                    s.lo      = row.lo;
                    s.mid     = row.mid;
                    s.hi      = row.hi;
                    if (row.typed && !reverse_all_q)
                    begin
                        want.adc = row.adc;
                        want.bad = row.bad;
                    end
                    else
                        want = scale_stick(s, reverse_all_q);
                    send_sample(s, want);
                end
            end
            repeat (RANDOM_PER_PHASE)
            begin
                s = make_sample();
                send_sample(s, scale_stick(s, reverse_all_q));
            end
            in_valid <= 1'b0;
        end
        wait_drained();
        repeat (LATENCY + 4)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_stick_calibration_scaler_unit: PASS");
        else
            $display("tb_stick_calibration_scaler_unit: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/scu_pkg.sv
src/scu_prep.sv
src/scu_div_cell.sv
src/scu_post.sv
src/stick_calibration_scaler_unit.sv
tb/tb_stick_calibration_scaler_unit.sv
